// ===== src/lkvc_pkg.sv =====
package lkvc_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic capture;  // latch the accepted item
    logic lookup;   // register match, victim and hit rank
    logic update;   // apply table changes and load the result
  } cmd_t;

endpackage

// ===== src/lkvc_ctrl.sv =====
module lkvc_ctrl import lkvc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_RESP   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready    = (state == ST_IDLE);
  assign out_valid   = (state == ST_RESP);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.lookup  = (state == ST_LOOKUP);
  assign cmd.update  = (state == ST_UPDATE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_RESP;
      ST_RESP:   if (out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/lkvc_datapath.sv =====
module lkvc_datapath import lkvc_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  input  logic                     op,
  input  logic signed [DATA_W-1:0] lookup_key,
  input  logic signed [DATA_W-1:0] write_value,
  input  logic                     cfg_we,
  input  logic        [CAP_W-1:0]  cfg_wdata,
  output logic                     hit,
  output logic signed [DATA_W-1:0] read_value,
  output logic                     evicted
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RW = IW;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [EW-1:0] MAX_EXT = EW'(MAX_ENTRIES);

  // table state
  logic [MAX_ENTRIES-1:0]   valid;
  logic signed [DATA_W-1:0] keys    [MAX_ENTRIES];
  logic [RW-1:0]            rank    [MAX_ENTRIES];
  logic signed [DATA_W-1:0] val_mem [MAX_ENTRIES];
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic [CAP_W-1:0]         capacity;

  // latched item
  logic                     req_op;
  logic signed [DATA_W-1:0] req_key;
  logic signed [DATA_W-1:0] req_val;

  // lookup results
  logic          lk_hit;
  logic [IW-1:0] lk_idx;
  logic [RW-1:0] lk_rank;
  logic          lk_evict;
  logic [IW-1:0] lk_victim;

  // result registers
  logic                     hit_r;
  logic                     ev_r;
  logic                     get_hit_r;
  logic signed [DATA_W-1:0] val_rdata;

  logic [MAX_ENTRIES-1:0] match_vec;
  logic [MAX_ENTRIES-1:0] victim_vec;
  logic [IW-1:0]          match_idx;
  logic [IW-1:0]          victim_idx;
  logic [RW-1:0]          cnt_m1;
  logic [EW-1:0]          eff_cap;
  logic                   full;

  logic [MAX_ENTRIES-1:0] valid_after;
  logic [MAX_ENTRIES-1:0] valid_next;
  logic [IW-1:0]          free_idx;
  logic                   free_any;
  logic                   insert;
  logic                   val_we;
  logic [IW-1:0]          val_waddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op  <= op;
      req_key <= lookup_key;
      req_val <= write_value;
    end
  end

  // Valid ranks are always 0..count-1, so the least recent entry is the one
  // ranked count-1.
  assign cnt_m1 = RW'(count - CW'(1));

  always_comb begin
    match_idx  = '0;
    victim_idx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match_vec[i]  = valid[i] && (keys[i] == req_key);
      victim_vec[i] = valid[i] && (rank[i] == cnt_m1);
    end
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) match_idx = IW'(i);
      if (victim_vec[i]) victim_idx = IW'(i);
    end
  end

  always_comb begin
    eff_cap = EW'(capacity);
    if (capacity == '0) eff_cap = EW'(1);
    if (eff_cap > MAX_EXT) eff_cap = MAX_EXT;
  end

  assign full = (EW'(count) >= eff_cap);

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      lk_hit    <= |match_vec;
      lk_idx    <= match_idx;
      lk_rank   <= rank[match_idx];
      lk_evict  <= (req_op == OP_PUT) && !(|match_vec) && full && (|victim_vec);
      lk_victim <= victim_idx;
    end
  end

  always_comb begin
    valid_after = valid;
    if (lk_evict) valid_after[lk_victim] = 1'b0;
    free_idx = '0;
    free_any = 1'b0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_after[i]) begin
        free_idx = IW'(i);
        free_any = 1'b1;
      end
    end
    valid_next = valid_after;
    if (insert) valid_next[free_idx] = 1'b1;
  end

  assign insert     = (req_op == OP_PUT) && !lk_hit && free_any;
  assign val_we     = cmd.update && ((lk_hit && (req_op == OP_PUT)) || insert);
  assign val_waddr  = lk_hit ? lk_idx : free_idx;
  assign count_next = count - CW'(lk_evict) + CW'(insert);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else if (cmd.update) begin
      valid <= valid_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (lk_hit) begin
          if (IW'(i) == lk_idx) rank[i] <= '0;
          else if (valid[i] && (rank[i] < lk_rank)) rank[i] <= rank[i] + RW'(1);
        end else if (insert) begin
          if (IW'(i) == free_idx) rank[i] <= '0;
          else if (valid_after[i]) rank[i] <= rank[i] + RW'(1);
        end
      end
      if (insert) keys[free_idx] <= req_key;
    end
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_waddr] <= req_val;
  end

  always_ff @(posedge clk) begin
    if (cmd.update) val_rdata <= val_mem[lk_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit_r     <= lk_hit;
      ev_r      <= lk_evict;
      get_hit_r <= lk_hit && (req_op == OP_GET);
    end
  end

  assign hit        = hit_r;
  assign evicted    = ev_r;
  assign read_value = get_hit_r ? val_rdata : '0;

endmodule

// ===== src/lru_key_value_cache.sv =====
// Flow: an accepted item passes through the lookup and update states, after
// which out_valid rises. The controller holds a single item from accept until
// its result is taken, so no new item is accepted in the meantime.
// Reset (rst, synchronous): all entries invalid, entry count zero, capacity 16,
// controller idle. Key and value storage is not cleared.
module lru_key_value_cache import lkvc_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     op,
  input  logic signed [DATA_W-1:0] lookup_key,
  input  logic signed [DATA_W-1:0] write_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     hit,
  output logic signed [DATA_W-1:0] read_value,
  output logic                     evicted,
  input  logic                     cfg_we,
  input  logic        [CAP_W-1:0]  cfg_wdata
);

  cmd_t cmd;

  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lkvc_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .op          (op),
    .lookup_key  (lookup_key),
    .write_value (write_value),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .hit         (hit),
    .read_value  (read_value),
    .evicted     (evicted)
  );

endmodule

// ===== src/lkvc_checker.sv =====
module lkvc_checker import lkvc_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     hit,
  input logic signed [DATA_W-1:0] read_value,
  input logic                     evicted
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(read_value)
      && $stable(evicted))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new item taken while one is in flight");

  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted |-> !hit)
    else $error("eviction reported on a hit");

  a_read_on_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (read_value != '0) |-> hit)
    else $error("nonzero read value without a hit");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import lkvc_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic                    hit;
    logic [DATA_W-1:0]       read_value;
    logic                    evicted;
  } access_result_t;

  // Tracks the cache contents and the results still owed by the block.
  class lru_scoreboard;
    logic [DATA_W-1:0] slot_key[TABLE_DEPTH];
    logic [DATA_W-1:0] slot_data[TABLE_DEPTH];
    bit                slot_used[TABLE_DEPTH];
    int unsigned       slot_rank[TABLE_DEPTH];
    int unsigned       used_count;
    logic [CAP_W-1:0]  capacity_reg;
    access_result_t    pending_results[$];
    int                errors;
    int                checked;
    int                hits_seen;
    int                evictions_seen;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_rank[i] = 0;
      end
      used_count = 0;
      capacity_reg = CAP_RESET;
      errors = 0;
      checked = 0;
      hits_seen = 0;
      evictions_seen = 0;
    endfunction

    function int unsigned usable_slots();
      if (capacity_reg == 0) return 1;
      if (capacity_reg > TABLE_DEPTH) return TABLE_DEPTH;
      return capacity_reg;
    endfunction

    // Ages valid entries ranked below the given limit.
    function void age_entries(int unsigned limit);
      foreach (slot_used[i])
        if (slot_used[i] && slot_rank[i] < limit) slot_rank[i]++;
    endfunction

    function void note_access(logic op_bit, logic [DATA_W-1:0] key,
                              logic [DATA_W-1:0] data);
      access_result_t res;
      int found;
      int victim;
      res = '0;
      found = -1;
      victim = -1;
      foreach (slot_used[i])
        if (found < 0 && slot_used[i] && slot_key[i] == key) found = i;
      if (found >= 0) begin
        res.hit = 1'b1;
        if (op_bit == OP_GET) res.read_value = slot_data[found];
        else slot_data[found] = data;
        age_entries(slot_rank[found]);
        slot_rank[found] = 0;
      end else if (op_bit == OP_PUT) begin
        // count may sit above capacity after a lowering; only one entry goes
        if (used_count >= usable_slots()) begin
          foreach (slot_used[i])
            if (slot_used[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
              victim = i;
          if (victim >= 0) begin
            slot_used[victim] = 1'b0;
            used_count--;
            res.evicted = 1'b1;
          end
        end
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!slot_used[i]) begin
            age_entries(TABLE_DEPTH);
            slot_used[i] = 1'b1;
            slot_key[i] = key;
            slot_data[i] = data;
            slot_rank[i] = 0;
            used_count++;
            break;
          end
        end
      end
      pending_results.insert(pending_results.size(), res);
    endfunction

    function void check_result(logic got_hit, logic [DATA_W-1:0] got_value,
                               logic got_evicted);
      access_result_t want;
      checked++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result with no access pending: hit %b value %h evicted %b",
                   got_hit, got_value, got_evicted);
        return;
      end
      want = pending_results.pop_front();
      if (want.hit) hits_seen++;
      if (want.evicted) evictions_seen++;
      if (got_hit !== want.hit || got_value !== want.read_value ||
          got_evicted !== want.evicted) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result %0d: hit %b/%b value %h/%h evicted %b/%b (exp/act)",
                   checked, want.hit, got_hit, want.read_value, got_value,
                   want.evicted, got_evicted);
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic                     op;
  logic signed [DATA_W-1:0] lookup_key;
  logic signed [DATA_W-1:0] write_value;
  logic                     out_valid;
  logic                     out_ready;
  logic                     hit;
  logic signed [DATA_W-1:0] read_value;
  logic                     evicted;
  logic                     cfg_we;
  logic        [CAP_W-1:0]  cfg_wdata;

  bit idling_on;
  bit hold_request;
  int items_sent;
  int settings_used;

  lru_scoreboard sb = new();

  lru_key_value_cache #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .lookup_key (lookup_key),
    .write_value(write_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .read_value (read_value),
    .evicted    (evicted),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int idle_gap();
    if (idling_on && $urandom_range(0, 3) == 0) return $urandom_range(1, 11);
    return 0;
  endfunction

  function automatic logic [DATA_W-1:0] random_key();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Called right after a rising edge; returns right after the accepting edge.
  // Handshake is sampled at the falling edge, where both sides are stable.
  task automatic send_access(input logic op_bit, input logic [DATA_W-1:0] key,
                             input logic [DATA_W-1:0] data, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= op_bit;
    lookup_key  <= key;
    write_value <= data;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    sb.note_access(op_bit, key, data);
    items_sent++;
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.capacity_reg = cap;
    settings_used++;
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int n_items,
                           input bit idle, input bit squeeze);
    logic [DATA_W-1:0] key_pool[$];
    logic [DATA_W-1:0] key;
    logic              op_bit;
    int                pool_n;
    write_capacity(cap);
    idling_on = idle;
    if (squeeze) hold_request = 1'b1;
    // pool a little larger than the table so hits and evictions both occur
    pool_n = sb.usable_slots() + $urandom_range(1, 6);
    repeat (pool_n) key_pool.insert(key_pool.size(), random_key());
    repeat (n_items) begin
      if ($urandom_range(0, 9) == 0) key = random_key();
      else key = key_pool[$urandom_range(0, pool_n - 1)];
      op_bit = ($urandom_range(0, 1) == 1) ? OP_PUT : OP_GET;
      send_access(op_bit, key, $urandom(), idle_gap());
    end
  endtask

  // Result side: random stalls plus one long hold-off on request.
  initial begin
    int  stall_left;
    int  hold_left;
    logic rdy;
    stall_left = 0;
    hold_left = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready <= rdy;
      @(negedge clk);
      if (out_valid && rdy) sb.check_result(hit, read_value, evicted);
      @(posedge clk);
    end
  end

  initial begin
    logic [CAP_W-1:0] cap_plan[12];
    bit               idle_plan[12];
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    op          <= OP_GET;
    lookup_key  <= '0;
    write_value <= '0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    idling_on = 1'b1;
    hold_request = 1'b0;
    items_sent = 0;
    settings_used = 0;
    cap_plan  = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd8, 5'd17, 5'd2, 5'd16, 5'd3,
                  5'd12, 5'd5};
    idle_plan = '{1, 1, 1, 0, 1, 1, 0, 1, 1, 1, 0, 0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty-table miss, field extremes, hits, overwrite
    send_access(OP_GET, 32'h0000_0000, 32'h1234_5678, idle_gap());
    send_access(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, idle_gap());
    send_access(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, idle_gap());
    send_access(OP_PUT, 32'h0000_0000, 32'h0000_0000, idle_gap());
    send_access(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, idle_gap());
    send_access(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF, idle_gap());
    send_access(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, idle_gap());
    send_access(OP_GET, 32'hFFFF_FFFF, 32'h5555_AAAA, idle_gap());
    send_access(OP_GET, 32'h0000_0000, 32'h0000_0000, idle_gap());
    send_access(OP_PUT, 32'h7FFF_FFFF, 32'h0000_0001, idle_gap());
    send_access(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, idle_gap());
    send_access(OP_GET, 32'h0000_0001, 32'h0000_0000, idle_gap());

    // capacity zero acts as one, and lies below the four entries held
    write_capacity(5'd0);
    send_access(OP_PUT, 32'h0000_0005, 32'hDEAD_BEEF, idle_gap());
    send_access(OP_PUT, 32'h0000_0006, 32'hCAFE_F00D, idle_gap());
    send_access(OP_GET, 32'h0000_0005, 32'h0000_0000, idle_gap());
    send_access(OP_GET, 32'h0000_0006, 32'h0000_0000, idle_gap());

    foreach (cap_plan[p])
      run_phase(cap_plan[p], 150, idle_plan[p], p == 3);

    drain_results();
    $display("Covered %0d accesses over %0d capacity settings, incl. a %0d-cycle result stall.",
             items_sent, settings_used, HOLD_CYCLES);
    $display("Checked %0d results: %0d hits, %0d evictions.",
             sb.checked, sb.hits_seen, sb.evictions_seen);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/lkvc_pkg.sv
src/lkvc_ctrl.sv
src/lkvc_datapath.sv
src/lru_key_value_cache.sv
src/lkvc_checker.sv
sim/testbench.sv
